// ===== design/bba_pkg.sv =====
// Shared types and constants for the block bitmap allocator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bba_pkg;

	localparam int MAX_BLOCKS_DEF = 4096;
	localparam int MAP_WORD_W     = 32;
	localparam int BIT_SEL_W      = 5;
	localparam int BLK_W          = 12;
	localparam int KIND_W         = 2;
	localparam int STAT_W         = 2;
	localparam int CNT_W          = 13;
	localparam int APB_DATA_W     = 32;
	localparam int APB_ADDR_W     = 3;
	localparam int IN_DATA_W      = 16;
	localparam int OUT_DATA_W     = 16;

	localparam logic [CNT_W-1:0] TOTAL_BLOCKS_RST = 13'd4096;
	localparam logic [0:0]       REG_TOTAL_BLOCKS = 1'b0;

	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL        = 2'd1;
	localparam logic [STAT_W-1:0] ST_DOUBLE_FREE = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_FREE_RD,
		S_FREE_CHK,
		S_RESP
	} state_t;

	typedef struct packed {
		logic clr_en;
		logic accept;
		logic scan_en;
		logic free_rd;
		logic free_chk;
		logic scan_fin;
		logic direct_fin;
		logic push_out;
	} dp_cmd_t;

	typedef struct packed {
		logic              clr_last;
		logic [KIND_W-1:0] kind;
		logic              blk_ok;
		logic              scan_done;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== design/bba_dp.sv =====
// Datapath of the block bitmap allocator: free map memory, scan pointer,
// first-fit search over one map word, result and output registers.
// Depends on bba_pkg; driven by bba_ctrl.
`default_nettype none

module bba_dp #(
	parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire bba_pkg::dp_cmd_t              cmd,
	output bba_pkg::dp_sts_t                   sts,
	input  wire [bba_pkg::KIND_W-1:0]          in_kind,
	input  wire [bba_pkg::BLK_W-1:0]           in_blk,
	input  wire [bba_pkg::CNT_W-1:0]           total_blocks,
	output logic [bba_pkg::OUT_DATA_W-1:0]     out_data
);

	localparam int WORDS = (MAX_BLOCKS + bba_pkg::MAP_WORD_W - 1) / bba_pkg::MAP_WORD_W;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BW    = AW + bba_pkg::BIT_SEL_W;
	localparam int LW    = $clog2(MAX_BLOCKS + 1);
	localparam int SW0   = (LW > BW) ? LW : BW;
	localparam int SW    = ((SW0 > bba_pkg::CNT_W) ? SW0 : bba_pkg::CNT_W) + 1;
	localparam int XW    = (BW > bba_pkg::BLK_W) ? BW : bba_pkg::BLK_W;
	localparam int CW    = ((XW > LW) ? XW : LW) + 1;

	logic [bba_pkg::MAP_WORD_W-1:0] map_mem [WORDS];

	logic [bba_pkg::KIND_W-1:0]     kind_q;
	logic [bba_pkg::BLK_W-1:0]      blk_q;
	logic [AW:0]                    ptr_q;
	logic                           chk_v_s1;
	logic [AW-1:0]                  chk_idx_s1;
	logic [bba_pkg::MAP_WORD_W-1:0] rdata_s1;
	logic [bba_pkg::BLK_W-1:0]      res_blk_q;
	logic [bba_pkg::STAT_W-1:0]     res_st_q;
	logic [bba_pkg::OUT_DATA_W-1:0] out_q;

	logic [SW-1:0]                  limit;
	logic [SW-1:0]                  base;
	logic [SW-1:0]                  base_end;
	logic [SW-1:0]                  rem;
	logic [bba_pkg::MAP_WORD_W-1:0] mask;
	logic [bba_pkg::MAP_WORD_W-1:0] free_bits;
	logic                           hit;
	logic [bba_pkg::BIT_SEL_W-1:0]  pos;
	logic                           scan_last;
	logic                           scan_done;

	logic [XW-1:0]                  blk_x;
	logic [AW-1:0]                  blk_word;
	logic [bba_pkg::BIT_SEL_W-1:0]  blk_bit;
	logic                           blk_ok;
	logic                           blk_set;

	logic                           ptr_ok;
	logic                           scan_issue;
	logic                           rd_en;
	logic [AW-1:0]                  rd_addr;
	logic                           wr_en;
	logic [AW-1:0]                  wr_addr;
	logic [bba_pkg::MAP_WORD_W-1:0] wr_data;

	assign limit = (SW'(total_blocks) > SW'(MAX_BLOCKS)) ? SW'(MAX_BLOCKS) : SW'(total_blocks);
	assign base     = SW'({chk_idx_s1, {bba_pkg::BIT_SEL_W{1'b0}}});
	assign base_end = base + SW'(bba_pkg::MAP_WORD_W);
	assign rem      = limit - base;

	always_comb begin
		if (limit >= base_end) begin
			mask = '1;
		end else if (limit <= base) begin
			mask = '0;
		end else begin
			mask = (bba_pkg::MAP_WORD_W'(1) << rem[bba_pkg::BIT_SEL_W-1:0]) -
				bba_pkg::MAP_WORD_W'(1);
		end
	end

	assign free_bits = ~rdata_s1 & mask;
	assign hit       = |free_bits;

	always_comb begin
		pos = '0;
		for (int j = bba_pkg::MAP_WORD_W - 1; j >= 0; j--) begin
			if (free_bits[j]) begin
				pos = bba_pkg::BIT_SEL_W'(j);
			end
		end
	end

	assign scan_last = (base_end >= limit) || (chk_idx_s1 == AW'(WORDS - 1));
	assign scan_done = chk_v_s1 & (hit | scan_last);

	assign blk_x    = XW'(blk_q);
	assign blk_word = blk_x[BW-1:bba_pkg::BIT_SEL_W];
	assign blk_bit  = blk_x[bba_pkg::BIT_SEL_W-1:0];
	assign blk_ok   = CW'(blk_q) < CW'(MAX_BLOCKS);
	assign blk_set  = rdata_s1[blk_bit];

	assign ptr_ok     = ptr_q < (AW + 1)'(WORDS);
	assign scan_issue = cmd.scan_en & ptr_ok & ~scan_done;
	assign rd_en      = scan_issue | cmd.free_rd;
	assign rd_addr    = cmd.free_rd ? blk_word : ptr_q[AW-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q[AW-1:0];
		wr_data = '0;
		if (cmd.clr_en) begin
			wr_en = 1'b1;
		end else if (cmd.scan_fin && hit && kind_q == bba_pkg::KIND_ALLOC) begin
			wr_en   = 1'b1;
			wr_addr = chk_idx_s1;
			wr_data = rdata_s1 | (bba_pkg::MAP_WORD_W'(1) << pos);
		end else if (cmd.free_chk && blk_set) begin
			wr_en   = 1'b1;
			wr_addr = blk_word;
			wr_data = rdata_s1 & ~(bba_pkg::MAP_WORD_W'(1) << blk_bit);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= map_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			chk_v_s1 <= 1'b0;
		end else begin
			chk_v_s1 <= scan_issue;
			if (cmd.accept) begin
				ptr_q <= '0;
			end else if (cmd.clr_en || scan_issue) begin
				ptr_q <= ptr_q + (AW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_issue) begin
			chk_idx_s1 <= ptr_q[AW-1:0];
		end
		if (cmd.accept) begin
			kind_q <= in_kind;
			blk_q  <= in_blk;
		end
		if (cmd.scan_fin) begin
			if (hit) begin
				res_blk_q <= (kind_q == bba_pkg::KIND_ALLOC) ?
					bba_pkg::BLK_W'({chk_idx_s1, pos}) : '0;
				res_st_q  <= bba_pkg::ST_OK;
			end else begin
				res_blk_q <= '0;
				res_st_q  <= bba_pkg::ST_FULL;
			end
		end else if (cmd.free_chk) begin
			res_blk_q <= '0;
			res_st_q  <= blk_set ? bba_pkg::ST_OK : bba_pkg::ST_DOUBLE_FREE;
		end else if (cmd.direct_fin) begin
			res_blk_q <= '0;
			res_st_q  <= (kind_q == bba_pkg::KIND_FREE) ? bba_pkg::ST_DOUBLE_FREE :
				bba_pkg::ST_OK;
		end
		if (cmd.push_out) begin
			out_q <= bba_pkg::OUT_DATA_W'({res_st_q, res_blk_q});
		end
	end

	assign out_data = out_q;

	assign sts.clr_last  = (ptr_q == (AW + 1)'(WORDS - 1));
	assign sts.kind      = kind_q;
	assign sts.blk_ok    = blk_ok;
	assign sts.scan_done = scan_done;

endmodule

`default_nettype wire

// ===== design/bba_ctrl.sv =====
// Controller of the block bitmap allocator: request sequencing state
// machine and output valid flag. Depends on bba_pkg; drives bba_dp.
`default_nettype none

module bba_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire                   out_ready,
	input  wire bba_pkg::dp_sts_t sts,
	output bba_pkg::dp_cmd_t      cmd
);

	bba_pkg::state_t state_q;
	bba_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = ~out_valid_q | out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bba_pkg::S_CLEAR: begin
				if (sts.clr_last) state_d = bba_pkg::S_IDLE;
			end
			bba_pkg::S_IDLE: begin
				if (in_valid) state_d = bba_pkg::S_DISPATCH;
			end
			bba_pkg::S_DISPATCH: begin
				if (sts.kind inside {bba_pkg::KIND_ALLOC, bba_pkg::KIND_QUERY}) begin
					state_d = bba_pkg::S_SCAN;
				end else if (sts.kind == bba_pkg::KIND_FREE && sts.blk_ok) begin
					state_d = bba_pkg::S_FREE_RD;
				end else begin
					state_d = bba_pkg::S_RESP;
				end
			end
			bba_pkg::S_SCAN: begin
				if (sts.scan_done) state_d = bba_pkg::S_RESP;
			end
			bba_pkg::S_FREE_RD:  state_d = bba_pkg::S_FREE_CHK;
			bba_pkg::S_FREE_CHK: state_d = bba_pkg::S_RESP;
			bba_pkg::S_RESP: begin
				if (out_free) state_d = bba_pkg::S_IDLE;
			end
			default: state_d = bba_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			bba_pkg::S_CLEAR: cmd.clr_en = 1'b1;
			bba_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			bba_pkg::S_DISPATCH: begin
				if (!(sts.kind inside {bba_pkg::KIND_ALLOC, bba_pkg::KIND_QUERY}) &&
					!(sts.kind == bba_pkg::KIND_FREE && sts.blk_ok)) begin
					cmd.direct_fin = 1'b1;
				end
			end
			bba_pkg::S_SCAN: begin
				cmd.scan_en  = 1'b1;
				cmd.scan_fin = sts.scan_done;
			end
			bba_pkg::S_FREE_RD:  cmd.free_rd = 1'b1;
			bba_pkg::S_FREE_CHK: cmd.free_chk = 1'b1;
			bba_pkg::S_RESP:     cmd.push_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bba_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== design/block_bitmap_allocator.sv =====
// Top level of the first-fit block bitmap allocator with its APB register.
// Depends on bba_pkg, bba_ctrl and bba_dp.
//
// Use: requests enter on the s_axis stream (tuser = kind, tdata = block
// number), one result word leaves on m_axis per request (block granted,
// status). total_blocks is to be written over APB only while the block is
// idle; the block itself does not enforce this. One request is worked at a
// time: a free passes DISPATCH, FREE_RD, FREE_CHK and RESP; an unused kind
// or a free beyond MAX_BLOCKS goes from DISPATCH straight to RESP; allocate
// and query pass DISPATCH, SCAN and RESP, where SCAN reads map words up to
// the first with a free block, at most (MAX_BLOCKS + 31) / 32 of them;
// the scan reads one map word per cycle from the single map memory port.
// The next request can be taken in the cycle after the result is registered.
// After reset the map memory is cleared one word per cycle, all (MAX_BLOCKS
// + 31) / 32 words, during which s_axis_tready stays low; APB writes are
// taken at all times. A stalled result is held in the output register
// while the next request is accepted and worked up to its result.
`default_nettype none

module block_bitmap_allocator #(
	parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire [bba_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // block_number[11:0]
	input  wire [bba_pkg::KIND_W-1:0]          s_axis_tuser,  // kind[1:0]
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	output logic [bba_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // allocated_block[11:0], status[13:12]
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire [bba_pkg::APB_ADDR_W-1:0]      paddr,
	input  wire [bba_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [bba_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);

	logic [bba_pkg::CNT_W-1:0] total_blocks_q;
	logic                      reg_sel;
	bba_pkg::dp_cmd_t          cmd;
	bba_pkg::dp_sts_t          sts;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[bba_pkg::APB_ADDR_W-1] == bba_pkg::REG_TOTAL_BLOCKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_blocks_q <= bba_pkg::TOTAL_BLOCKS_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			total_blocks_q <= pwdata[bba_pkg::CNT_W-1:0];
		end
	end

	assign prdata = reg_sel ? bba_pkg::APB_DATA_W'(total_blocks_q) : '0;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bba_dp #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_kind      (s_axis_tuser),
		.in_blk       (s_axis_tdata[bba_pkg::BLK_W-1:0]),
		.total_blocks (total_blocks_q),
		.out_data     (m_axis_tdata)
	);

endmodule

`default_nettype wire

// ===== design/bba_checker.sv =====
// Port-level checks for block_bitmap_allocator, bound to the top level.
// Depends on bba_pkg.
`default_nettype none

module bba_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            s_axis_tvalid,
	input wire                            s_axis_tready,
	input wire                            m_axis_tvalid,
	input wire                            m_axis_tready,
	input wire [bba_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while another is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[13:12] == bba_pkg::ST_OK ||
			m_axis_tdata[13:12] == bba_pkg::ST_FULL ||
			m_axis_tdata[13:12] == bba_pkg::ST_DOUBLE_FREE)
		else $error("undefined status code");

	a_err_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[13:12] != bba_pkg::ST_OK |->
			m_axis_tdata[11:0] == '0)
		else $error("block number reported with error status");

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== bench/tb_block_bitmap_allocator.sv =====
// Self-checking bench for block_bitmap_allocator: allocate, free and query
// words on the request stream, total_blocks over APB, results scored in order.
// Depends on bba_pkg and the block_bitmap_allocator RTL.

module tb_block_bitmap_allocator;

	import bba_pkg::*;

	localparam int MAP_BITS = MAX_BLOCKS_DEF;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_WORDS = 1200;
	localparam int TAIL_CYCLES = 140;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [APB_ADDR_W-1:0] ADDR_TOTAL_BLOCKS = {REG_TOTAL_BLOCKS, 2'b00};

	typedef struct packed {
		logic [BLK_W-1:0]  blk;
		logic [STAT_W-1:0] status;
	} alloc_result_t;

	class alloc_scoreboard;
		bit held [MAP_BITS];
		logic [CNT_W-1:0] block_count;
		alloc_result_t expected_q[$];
		int fail_count;

		function new();
			foreach (held[i])
				held[i] = 1'b0;
			block_count = TOTAL_BLOCKS_RST;
			fail_count = 0;
		endfunction

		function void set_count(logic [CNT_W-1:0] value);
			block_count = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// lowest free block below the managed count, saturated to the map size
		function bit find_free(output int where);
			int limit;
			int b;
			limit = (block_count > MAP_BITS) ? MAP_BITS : int'(block_count);
			where = 0;
			for (b = 0; b < limit; b++) begin
				if (!held[b]) begin
					where = b;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function bit pick_held(output logic [BLK_W-1:0] blk);
			int start;
			int idx;
			start = $urandom_range(0, MAP_BITS - 1);
			blk = '0;
			for (int i = 0; i < MAP_BITS; i++) begin
				idx = (start + i) % MAP_BITS;
				if (held[idx]) begin
					blk = idx[BLK_W-1:0];
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void note_request(logic [KIND_W-1:0] kind, logic [BLK_W-1:0] blk);
			alloc_result_t res;
			int free_blk;
			res.blk = '0;
			res.status = ST_OK;
			case (kind)
				KIND_ALLOC: begin
					if (find_free(free_blk)) begin
						held[free_blk] = 1'b1;
						res.blk = free_blk[BLK_W-1:0];
					end else begin
						res.status = ST_FULL;
					end
				end
				KIND_FREE: begin
					if (held[blk])
						held[blk] = 1'b0;
					else
						res.status = ST_DOUBLE_FREE;
				end
				KIND_QUERY: begin
					if (!find_free(free_blk))
						res.status = ST_FULL;
				end
				default: ;
			endcase
			expected_q.push_back(res);
		endfunction

		task report(string msg);
			fail_count++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_result(logic [BLK_W-1:0] blk, logic [STAT_W-1:0] status);
			alloc_result_t exp;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result block %0d status %0d", blk, status));
				return;
			end
			exp = expected_q.pop_front();
			if (blk !== exp.blk)
				report($sformatf("allocated_block %0d, want %0d", blk, exp.blk));
			if (status !== exp.status)
				report($sformatf("status %0d, want %0d", status, exp.status));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [KIND_W-1:0]     s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	alloc_scoreboard sb = new();
	bit steady;
	bit hold_off;
	int cycle_count;

	block_bitmap_allocator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** block_bitmap_allocator: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata[BLK_W-1:0], m_axis_tdata[BLK_W+STAT_W-1:BLK_W]);
	end

	// result side: random stalls, plus one long hold when asked
	initial begin
		int hold_left;
		int idle_left;
		hold_left = 0;
		idle_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				hold_left = HOLD_CYCLES;
				hold_off = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready = 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = 1'b1;
				if (!steady)
					idle_left = idle_len();
			end
		end
	end

	// call at a falling edge; returns at the falling edge after acceptance
	task send_request(logic [KIND_W-1:0] kind, logic [BLK_W-1:0] blk);
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = kind;
		s_axis_tdata = {{(IN_DATA_W - BLK_W){1'b0}}, blk};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_request(kind, blk);
		@(negedge clk);
	endtask

	task wait_drain();
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task program_block_count(logic [CNT_W-1:0] value);
		logic [APB_DATA_W-1:0] rd;
		wait_drain();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ADDR_TOTAL_BLOCKS;
		pwdata = {{(APB_DATA_W - CNT_W){1'b0}}, value};
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		sb.set_count(value);
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rd = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (rd !== {{(APB_DATA_W - CNT_W){1'b0}}, value})
			sb.report($sformatf("total_blocks reads %0h, want %0h", rd, value));
	endtask

	initial begin
		int sent;
		int phase;
		int r;
		int bias;
		int span;
		int rest;
		logic [KIND_W-1:0] kind;
		logic [BLK_W-1:0] blk;
		logic [CNT_W-1:0] count;

		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		steady = 1'b0;
		hold_off = 1'b0;
		cycle_count = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset count, first grants, double free, unused kind
		send_request(KIND_QUERY, 12'h000);
		send_request(KIND_ALLOC, 12'h000);
		send_request(KIND_ALLOC, 12'hFFF);
		send_request(KIND_FREE, 12'd1);
		send_request(KIND_FREE, 12'd1);
		send_request(KIND_FREE, 12'hFFF);
		send_request(KIND_UNUSED, 12'hFFF);
		send_request(KIND_ALLOC, 12'h555);
		// zero count: nothing managed, granted bit above the count still frees
		program_block_count(13'd0);
		send_request(KIND_ALLOC, 12'hAAA);
		send_request(KIND_QUERY, 12'hFFF);
		send_request(KIND_FREE, 12'd1);
		send_request(KIND_FREE, 12'd1);
		// count above the map saturates
		program_block_count(13'h1FFF);
		send_request(KIND_ALLOC, 12'h000);
		send_request(KIND_QUERY, 12'h000);
		// single block
		program_block_count(13'd1);
		send_request(KIND_ALLOC, 12'h000);
		send_request(KIND_QUERY, 12'h000);
		send_request(KIND_FREE, 12'd0);
		send_request(KIND_ALLOC, 12'h000);
		send_request(KIND_FREE, 12'd1);
		program_block_count(TOTAL_BLOCKS_RST);

		sent = 0;
		phase = 0;
		while (sent < RANDOM_WORDS) begin
			r = $urandom_range(0, 9);
			if (r < 4)
				count = 13'($urandom_range(1, 48));
			else if (r < 6)
				count = 13'($urandom_range(49, 600));
			else if (r == 6)
				count = TOTAL_BLOCKS_RST;
			else if (r == 7)
				count = 13'($urandom_range(4097, 8191));
			else if (r == 8)
				count = 13'($urandom_range(0, 1));
			else
				count = 13'($urandom_range(601, 4095));
			program_block_count(count);
			steady = (phase == 0) || ($urandom_range(0, 3) == 0);
			if (phase == 0 || $urandom_range(0, 9) == 0)
				hold_off = 1'b1;
			bias = $urandom_range(30, 80);
			span = 100 - bias;
			repeat ($urandom_range(60, 120)) begin
				r = $urandom_range(0, 99);
				blk = 12'($urandom_range(0, MAP_BITS - 1));
				rest = r - bias;
				if (r < bias)
					kind = KIND_ALLOC;
				else if (rest < span * 60 / 100) begin
					kind = KIND_FREE;
					void'(sb.pick_held(blk));
				end else if (rest < span * 75 / 100)
					kind = KIND_FREE;
				else if (rest < span * 93 / 100)
					kind = KIND_QUERY;
				else
					kind = KIND_UNUSED;
				send_request(kind, blk);
				sent++;
			end
			s_axis_tvalid = 1'b0;
			phase++;
		end

		wait_drain();
		steady = 1'b0;
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.fail_count == 0)
			$display("** block_bitmap_allocator: PASSED **");
		else
			$display("** block_bitmap_allocator: FAILED **");
		$finish;
	end

endmodule
